// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Delayed implication, disabled while reset is asserted.
`define ASSERT_DLY3(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##3 (cons)) \
        else $error("assertion failed: delayed implication");

`endif

// ===== design/dcga_pkg.sv =====
// Types, constants and the offset decode function of the gather address core.
`default_nettype none

package dcga_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [7:0] EXP_BIAS    = 8'd127;
    localparam logic [7:0] EXP_SAT     = 8'd135;  // shift of 8 or more saturates
    localparam logic [7:0] MANT_HIDDEN = 8'h80;
    localparam logic [7:0] INT_SAT     = 8'hff;
    localparam logic [6:0] OFFSET_BIAS = 7'd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEIGHT    = 3'd0,
        REG_WIDTH     = 3'd1,
        REG_CHANNELS  = 3'd2,
        REG_COL_START = 3'd3,
        REG_ROW_STEP  = 3'd4,
        REG_COL_STEP  = 3'd5,
        REG_COL_END   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] channels;
        logic [15:0] col_start;
        logic [15:0] row_step;
        logic [15:0] col_step;
        logic [15:0] col_end;
    } cfg_t;

    typedef struct packed {
        logic [15:0] offset_h_raw;
        logic [15:0] offset_w_raw;
        logic [15:0] row_tap;
        logic [15:0] col_tap;
        logic [1:0]  corner;
        logic [31:0] image_base;
        logic        restart;
        logic [15:0] restart_row;
        logic [15:0] restart_col;
    } in_item_t;

    typedef struct packed {
        logic                  zero_fill;
        logic [ADDR_WIDTH-1:0] src_addr;
        logic [15:0]           next_row;
        logic [15:0]           next_col;
    } out_item_t;

    typedef struct packed {
        logic load_in;   // input transfer: position stage and counters
        logic mul_pix;   // pixel index stage
        logic load_out;  // address stage into the output register
    } dp_cmd_t;

    // Integer part of a bfloat16 value, zero below one, saturating at 255.
    function automatic logic [7:0] decode_offset(input logic [15:0] raw);
        logic [7:0]  e;
        logic [7:0]  amt;
        logic [14:0] sh;
        e   = raw[14:7];
        amt = e - EXP_BIAS;
        sh  = 15'({MANT_HIDDEN[7], raw[6:0]}) << amt[2:0];
        if (raw[15] || (e < EXP_BIAS)) begin
            return 8'd0;
        end else if (e >= EXP_SAT) begin
            return INT_SAT;
        end else begin
            return sh[14:7];
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/dcga_cfg_regs.sv =====
// Configuration register file of the gather address core.
`default_nettype none

module dcga_cfg_regs
    import dcga_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [15:0]          wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (cfg_idx_t'(wr_index))
                REG_HEIGHT:    cfg_next.height    = wr_data;
                REG_WIDTH:     cfg_next.width     = wr_data;
                REG_CHANNELS:  cfg_next.channels  = wr_data;
                REG_COL_START: cfg_next.col_start = wr_data;
                REG_ROW_STEP:  cfg_next.row_step  = wr_data;
                REG_COL_STEP:  cfg_next.col_step  = wr_data;
                REG_COL_END:   cfg_next.col_end   = wr_data;
                default:       cfg_next = cfg_reg;  // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.height    <= 16'd1;
            cfg_reg.width     <= 16'd1;
            cfg_reg.channels  <= 16'd32;
            cfg_reg.col_start <= 16'd0;
            cfg_reg.row_step  <= 16'd1;
            cfg_reg.col_step  <= 16'd1;
            cfg_reg.col_end   <= 16'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/dcga_ctrl.sv =====
// Controller state machine: sequences each item through the datapath stages.
`default_nettype none

module dcga_ctrl
    import dcga_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output dp_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_ADDR) && out_free);
    assign accept   = s_valid && s_ready;

    assign cmd.load_in  = accept;
    assign cmd.mul_pix  = (state_reg == ST_MUL);
    assign cmd.load_out = (state_reg == ST_ADDR) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                if (out_free) state_next = accept ? ST_MUL : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/dcga_datapath.sv =====
// Datapath: offset decode, position and bounds, counters, pixel index, address.
`default_nettype none

module dcga_datapath
    import dcga_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire dp_cmd_t  cmd,
    input  wire in_item_t in_item,
    output out_item_t     out_item
);

    // running counters
    logic [15:0] row_pos_reg, row_pos_next;
    logic [15:0] col_pos_reg, col_pos_next;

    // position stage
    logic [15:0] h_reg, w_reg;
    logic        inb1_reg;
    logic [31:0] base1_reg;
    logic [15:0] nrow1_reg, ncol1_reg;

    // pixel index stage
    logic [31:0] pix_reg;
    logic        inb2_reg;
    logic [31:0] base2_reg;
    logic [15:0] nrow2_reg, ncol2_reg;

    out_item_t out_reg;

    logic [15:0] row_eff, col_eff;
    logic [7:0]  int_h, int_w;
    logic [18:0] h_sum, w_sum;
    logic        inb_h, inb_w;
    logic [16:0] col_sum;
    logic        col_wrap;
    logic [31:0] pix_next;
    logic [31:0] scaled;

    assign row_eff = in_item.restart ? in_item.restart_row : row_pos_reg;
    assign col_eff = in_item.restart ? in_item.restart_col : col_pos_reg;
    assign int_h   = decode_offset(in_item.offset_h_raw);
    assign int_w   = decode_offset(in_item.offset_w_raw);

    // 19-bit two's complement: low end is -63, high end fits in 18 bits
    assign h_sum = 19'(row_eff) + 19'(in_item.row_tap) + 19'(int_h)
                 + 19'(in_item.corner[1]) - 19'(OFFSET_BIAS);
    assign w_sum = 19'(col_eff) + 19'(in_item.col_tap) + 19'(int_w)
                 + 19'(in_item.corner[0]) - 19'(OFFSET_BIAS);
    assign inb_h = !h_sum[18] && (h_sum[17:0] < 18'(cfg.height));
    assign inb_w = !w_sum[18] && (w_sum[17:0] < 18'(cfg.width));

    // column advance, compared at 17 bits
    assign col_sum  = 17'(col_eff) + 17'(cfg.col_step);
    assign col_wrap = (col_sum >= 17'(cfg.col_end));

    always_comb begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cmd.load_in) begin
            if (col_wrap) begin
                col_pos_next = cfg.col_start;
                row_pos_next = row_eff + cfg.row_step;
            end else begin
                col_pos_next = col_sum[15:0];
                row_pos_next = row_eff;
            end
        end
    end

    // h < height and w < width, so h*width + w stays below 2^32
    assign pix_next = (32'(h_reg) * 32'(cfg.width)) + 32'(w_reg);
    assign scaled   = pix_reg * 32'(cfg.channels);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end else begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            h_reg     <= h_sum[15:0];
            w_reg     <= w_sum[15:0];
            inb1_reg  <= inb_h && inb_w;
            base1_reg <= in_item.image_base;
            nrow1_reg <= row_pos_next;
            ncol1_reg <= col_pos_next;
        end
        if (cmd.mul_pix) begin
            pix_reg   <= pix_next;
            inb2_reg  <= inb1_reg;
            base2_reg <= base1_reg;
            nrow2_reg <= nrow1_reg;
            ncol2_reg <= ncol1_reg;
        end
        if (cmd.load_out) begin
            out_reg.zero_fill <= !inb2_reg;
            out_reg.src_addr  <= inb2_reg ? ADDR_WIDTH'(base2_reg + scaled) : '0;
            out_reg.next_row  <= nrow2_reg;
            out_reg.next_col  <= ncol2_reg;
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// ===== design/deform_conv_gather_address_core.sv =====
// Top level of the deformable convolution gather address core.
//
// Usage:
//   s_valid/s_ready/s_data   input items (in_item_t); a transfer happens when
//                            valid and ready are both high at a clock edge.
//   m_valid/m_ready/m_data   one result (out_item_t) per input item, in order.
//   cfg_valid/cfg_ready      register writes, cfg_index selects the register
//   cfg_index/cfg_data       (0 height .. 6 col_end); cfg_ready is always high.
//                            Write only while no item is in flight.
// Stages: an accepted item passes the position stage, then the pixel index
//   multiply, then the address multiply-add into the output register, which
//   it enters, with m_valid, once the output is free.
// Overlap: limited by the two multiplier stages that each item passes in turn.
//   The next item is taken in the cycle the previous one moves into the output
//   register.
// Stall: a waiting result stays in the output register; the item behind it
//   waits in the address stage and s_ready stays low until m_ready.
// Reset (aresetn, synchronous, active low): configuration registers go to
//   their defaults, row and column counters clear, no result is pending.
`default_nettype none
`include "assert_macros.svh"

module deform_conv_gather_address_core
    import dcga_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    // configuration writes never stall
    assign cfg_ready = 1'b1;

    dcga_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dcga_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dcga_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .in_item  (s_data),
        .out_item (m_data)
    );

    // an out-of-image result carries a zero address
    `ASSERT_IMP(a_zero_fill_addr, aclk, aresetn, m_valid && m_data.zero_fill, m_data.src_addr == '0)
    // after a transfer in, the pixel index stage runs and input is closed
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // an accepted item later finds m_valid high: it has reached or waits behind the output register
    `ASSERT_DLY3(a_result_pending, aclk, aresetn, s_valid && s_ready, m_valid)

endmodule

`default_nettype wire
